>>> rtl/core/scp_pkg.sv
package scp_pkg;

  localparam int MaxLen     = 7;
  localparam int StoreDepth = 7;
  localparam int CapLenInt  = (MaxLen < StoreDepth) ? MaxLen : StoreDepth;

  localparam logic [2:0] CapLen = 3'(CapLenInt);

  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharG     = 8'h67;
  localparam logic [7:0] CharS     = 8'h73;
  localparam logic [7:0] CharT     = 8'h74;
  localparam logic [7:0] CharA     = 8'h61;
  localparam logic [7:0] CharC     = 8'h63;
  localparam logic [7:0] CharE     = 8'h65;

  localparam logic KindGet = 1'b0;
  localparam logic KindSet = 1'b1;

  localparam logic [1:0] ParamTemp   = 2'd0;
  localparam logic [1:0] ParamHeater = 2'd1;
  localparam logic [1:0] ParamCooler = 2'd2;
  localparam logic [1:0] ParamEnable = 2'd3;

  typedef struct packed {
    logic        cmd_kind;
    logic [1:0]  param_code;
    logic [2:0]  value_length;
    logic [55:0] value_chars;
  } cmd_t;

endpackage

>>> rtl/core/scp_ifs.sv
interface scp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scp_cmd_if;
  logic        valid;
  logic        ready;
  logic        cmd_kind;
  logic [1:0]  param_code;
  logic [2:0]  value_length;
  logic [55:0] value_chars;

  modport source (output valid, output cmd_kind, output param_code, output value_length,
                  output value_chars, input ready);
  modport sink (input valid, input cmd_kind, input param_code, input value_length,
                input value_chars, output ready);
endinterface

>>> rtl/core/scp_in_reg.sv
module scp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_q
);

  assign in_ready = !byte_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid <= 1'b1;
    end else if (take) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= in_byte;
    end
  end

endmodule

>>> rtl/core/scp_parser.sv
module scp_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [7:0]   rx_byte,
  output logic         res_valid,
  output scp_pkg::cmd_t res
);
  import scp_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StReady = 3'd1;
  localparam logic [2:0] StGet   = 3'd2;
  localparam logic [2:0] StSet   = 3'd3;
  localparam logic [2:0] StParam = 3'd4;
  localparam logic [2:0] StValue = 3'd5;

  logic [2:0] parser_state, parser_state_next;
  logic [1:0] pending_param, pending_param_next;
  logic [2:0] char_count, char_count_next;
  logic [7:0] value_store [StoreDepth];
  logic       store_we;

  logic       is_param;
  logic [1:0] param_dec;
  logic       is_value_char;
  logic [55:0] packed_chars;

  always_comb begin
    is_param  = 1'b1;
    param_dec = ParamTemp;
    case (rx_byte)
      CharT:   param_dec = ParamTemp;
      CharA:   param_dec = ParamHeater;
      CharC:   param_dec = ParamCooler;
      CharE:   param_dec = ParamEnable;
      default: is_param  = 1'b0;
    endcase
  end

  assign is_value_char = ((rx_byte >= CharZero) && (rx_byte <= CharNine)) ||
                         (rx_byte == CharComma);

  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      packed_chars[8*i +: 8] = (3'(i) < char_count) ? value_store[i] : 8'h00;
    end
  end

  always_comb begin
    parser_state_next  = parser_state;
    pending_param_next = pending_param;
    char_count_next    = char_count;
    store_we           = 1'b0;
    res_valid          = 1'b0;
    res.cmd_kind       = KindGet;
    res.param_code     = pending_param;
    res.value_length   = 3'd0;
    res.value_chars    = 56'd0;
    if (en) begin
      if (rx_byte == CharHash) begin
        parser_state_next = StReady;
      end else begin
        unique case (parser_state)
          StReady: begin
            if (rx_byte == CharG) begin
              parser_state_next = StGet;
            end else if (rx_byte == CharS) begin
              parser_state_next = StSet;
            end else begin
              parser_state_next = StIdle;
            end
          end
          StGet: begin
            if (is_param && (param_dec != ParamEnable)) begin
              pending_param_next = param_dec;
              parser_state_next  = StParam;
            end else begin
              parser_state_next = StIdle;
            end
          end
          StSet: begin
            if (is_param) begin
              pending_param_next = param_dec;
              char_count_next    = 3'd0;
              parser_state_next  = StValue;
            end else begin
              parser_state_next = StIdle;
            end
          end
          StParam: begin
            parser_state_next = StIdle;
            res_valid         = (rx_byte == CharSemi);
          end
          StValue: begin
            if (is_value_char) begin
              if (char_count < CapLen) begin
                store_we        = 1'b1;
                char_count_next = char_count + 3'd1;
              end
            end else begin
              parser_state_next = StIdle;
              res_valid         = (rx_byte == CharSemi);
              res.cmd_kind      = KindSet;
              res.value_length  = char_count;
              res.value_chars   = packed_chars;
            end
          end
          default: begin
            parser_state_next = StIdle;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parser_state  <= StIdle;
      pending_param <= ParamTemp;
      char_count    <= 3'd0;
    end else begin
      parser_state  <= parser_state_next;
      pending_param <= pending_param_next;
      char_count    <= char_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      value_store[char_count] <= rx_byte;
    end
  end

endmodule

>>> rtl/core/scp_out_reg.sv
module scp_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  scp_pkg::cmd_t data_in,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output scp_pkg::cmd_t data_q
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= data_in;
    end
  end

endmodule

>>> rtl/core/serial_command_parser_core.sv
// A completed command is presented on the result channel once the transaction carrying its
// closing ';' has passed the input register and then been loaded into the result register.
// Throughput: one byte per cycle while the result register is free to take a new result.
// Reset: synchronous, active-high rst empties both registers and returns the parser to idle;
// the stored value characters are not cleared and are only read after being written.
module serial_command_parser_core (
  input logic   clk,
  input logic   rst,
  scp_rx_if.sink   rx,
  scp_cmd_if.source cmd
);
  import scp_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  cmd_t       res;
  cmd_t       res_q;

  assign advance = byte_valid && out_free;

  scp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_byte    (rx.rx_byte),
    .in_ready   (rx.ready),
    .take       (advance),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  scp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .rx_byte   (byte_q),
    .res_valid (res_valid),
    .res       (res)
  );

  scp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .data_in   (res),
    .free      (out_free),
    .out_valid (cmd.valid),
    .out_ready (cmd.ready),
    .data_q    (res_q)
  );

  assign cmd.cmd_kind     = res_q.cmd_kind;
  assign cmd.param_code   = res_q.param_code;
  assign cmd.value_length = res_q.value_length;
  assign cmd.value_chars  = res_q.value_chars;

`ifndef SYNTHESIS
  a_get_no_value: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && (cmd.cmd_kind == KindGet)) |->
      ((cmd.value_length == 3'd0) && (cmd.value_chars == 56'd0)))
    else $error("get result carries value characters");

  a_length_capped: assert property (@(posedge clk) disable iff (rst)
    cmd.valid |-> (cmd.value_length <= CapLen))
    else $error("value length exceeds the kept limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && !cmd.ready) |-> !res_valid)
    else $error("new result produced while the held result is stalled");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !out_free) |=> (byte_valid && $stable(byte_q)))
    else $error("input byte lost while the result side is stalled");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import scp_pkg::*;

  localparam int HoldoffCycles = 400;
  localparam int WatchdogLimit = 4000;
  localparam int TailCycles    = 8;

  typedef enum logic [2:0] {
    PsIdle,
    PsLead,
    PsGetParam,
    PsSetParam,
    PsGetEnd,
    PsValue
  } parse_state_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst = 1'b1;

  scp_rx_if  rx_if ();
  scp_cmd_if cmd_if ();

  serial_command_parser_core u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .cmd (cmd_if)
  );

  always #5ns clk = ~clk;

  parse_state_t parse_state  = PsIdle;
  logic [1:0]   pending_code = ParamTemp;
  logic [2:0]   kept_count   = '0;
  logic [7:0]   kept_chars[StoreDepth];

  cmd_t parsed_cmds[$];
  int   mismatches    = 0;
  int   idle_pct      = 0;
  int   stall_pct     = 0;
  int   holdoff_asks  = 0;
  int   holdoff_done  = 0;
  int   quiet_cycles  = 0;

  function automatic bit decode_rx_byte(input logic [7:0] b, output cmd_t c);
    bit done;
    done = 1'b0;
    c = '0;
    if (b == CharHash) begin
      parse_state = PsLead;
      return 1'b0;
    end
    case (parse_state)
      PsLead: begin
        if (b == CharG) parse_state = PsGetParam;
        else if (b == CharS) parse_state = PsSetParam;
        else parse_state = PsIdle;
      end
      PsGetParam, PsSetParam: begin
        parse_state = (parse_state == PsGetParam) ? PsGetEnd : PsValue;
        kept_count = '0;
        case (b)
          CharT: pending_code = ParamTemp;
          CharA: pending_code = ParamHeater;
          CharC: pending_code = ParamCooler;
          CharE: begin
            if (parse_state == PsValue) pending_code = ParamEnable;
            else parse_state = PsIdle;
          end
          default: parse_state = PsIdle;
        endcase
      end
      PsGetEnd: begin
        parse_state = PsIdle;
        if (b == CharSemi) begin
          c.cmd_kind = KindGet;
          c.param_code = pending_code;
          done = 1'b1;
        end
      end
      PsValue: begin
        if ((b >= CharZero && b <= CharNine) || b == CharComma) begin
          if (kept_count < CapLen) begin
            kept_chars[kept_count] = b;
            kept_count++;
          end
        end else begin
          parse_state = PsIdle;
          if (b == CharSemi) begin
            c.cmd_kind = KindSet;
            c.param_code = pending_code;
            c.value_length = kept_count;
            for (int i = 0; i < int'(kept_count); i++) c.value_chars[8*i +: 8] = kept_chars[i];
            done = 1'b1;
          end
        end
      end
      default: parse_state = PsIdle;
    endcase
    return done;
  endfunction

  function automatic byte_q_t make_command();
    byte_q_t    seq;
    logic [7:0] set_letters[4] = '{CharT, CharE, CharA, CharC};
    logic [7:0] get_letters[4] = '{CharT, CharA, CharC, CharE};
    int         pick;
    int         len;
    int         r;
    pick = $urandom_range(99);
    if (pick < 15) begin
      repeat ($urandom_range(3, 1)) seq.push_back(8'($urandom_range(255)));
      return seq;
    end
    seq.push_back(CharHash);
    if ($urandom_range(1) == 0) begin
      seq.push_back(CharG);
      seq.push_back(get_letters[($urandom_range(19) == 0) ? 3 : $urandom_range(2)]);
    end else begin
      seq.push_back(CharS);
      seq.push_back(set_letters[$urandom_range(3)]);
      len = ($urandom_range(7) == 0) ? $urandom_range(12, 8) : $urandom_range(7);
      repeat (len) begin
        r = $urandom_range(10);
        seq.push_back((r == 10) ? CharComma : CharZero + 8'(r));
      end
    end
    seq.push_back(CharSemi);
    if (pick < 25) begin
      if ($urandom_range(1) == 0) seq.pop_back();
      else seq[$urandom_range(seq.size() - 1)] = 8'($urandom_range(255));
    end
    return seq;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    cmd_t c;
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    if (decode_rx_byte(b, c)) parsed_cmds.push_back(c);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      rx_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_commands(input int n_bytes);
    byte_q_t seq;
    int      sent;
    sent = 0;
    while (sent < n_bytes) begin
      seq = make_command();
      foreach (seq[i]) send_byte(seq[i]);
      sent += seq.size();
    end
  endtask

  task automatic pause_sender();
    rx_if.valid <= 1'b0;
    do @(negedge clk); while (parsed_cmds.size() != 0);
  endtask

  task automatic test_directed_cases();
    idle_pct = 0;
    stall_pct = 0;
    send_text("#ga;");
    send_text("#sc;");
    send_text("#gt");
    send_byte(8'hFF);
    send_text("#ge");
    send_byte(8'h00);
    send_text("#se#st90,12345;");
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int n_bytes);
    idle_pct = idle;
    stall_pct = stall;
    send_commands(n_bytes);
  endtask

  task automatic test_receiver_holdoff();
    idle_pct = 0;
    stall_pct = 0;
    holdoff_asks++;
    send_commands(48);
  endtask

  task automatic test_drain_pause();
    idle_pct = 29;
    stall_pct = 29;
    send_commands(20);
    pause_sender();
    send_commands(20);
  endtask

  initial begin
    cmd_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_asks != holdoff_done) begin
        cmd_if.ready <= 1'b0;
        repeat (HoldoffCycles) @(negedge clk);
        holdoff_done++;
      end
      cmd_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_field(input string name, input logic [55:0] want,
                              input logic [55:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cmd_t want;
    if (!rst && cmd_if.valid && cmd_if.ready) begin
      if (parsed_cmds.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual kind %0d param %0d len %0d value %0h",
                 $time, cmd_if.cmd_kind, cmd_if.param_code, cmd_if.value_length,
                 cmd_if.value_chars);
      end else begin
        want = parsed_cmds.pop_front();
        report_field("cmd_kind", 56'(want.cmd_kind), 56'(cmd_if.cmd_kind));
        report_field("param_code", 56'(want.param_code), 56'(cmd_if.param_code));
        report_field("value_length", 56'(want.value_length), 56'(cmd_if.value_length));
        report_field("value_chars", want.value_chars, cmd_if.value_chars);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("serial_command_parser_core: mismatch");
      $finish;
    end
  end

  initial begin
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic(0, 0, 280);
    test_random_traffic(86, 0, 280);
    test_random_traffic(0, 86, 280);
    test_random_traffic(29, 29, 280);
    test_receiver_holdoff();
    test_drain_pause();
    pause_sender();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("serial_command_parser_core: match");
    end else begin
      $display("serial_command_parser_core: mismatch");
    end
    $finish;
  end

endmodule
